### sv/imutcf_pkg.sv
// Shared types, constants and helper functions for the IMU tilt complementary filter.
// Used by the controller, the datapath, the angle lanes and the top level. No dependencies.
`default_nettype none
package imutcf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CORDIC_STEPS    = 16;
    localparam int TABLE_FRAC      = 24;
    localparam int ONE_G           = 16384;
    localparam int GAIN_ONE        = 32768;
    localparam int GAIN_SHIFT      = 15;
    localparam int GYRO_DIV        = 131000;
    localparam int GYRO_HALF       = GYRO_DIV / 2;

    // The gyro step divider finishes during the CORDIC iterations.
    localparam int ITER_CYCLES = CORDIC_STEPS;
    localparam int CNT_W       = ($clog2(ITER_CYCLES + 1) > 5) ? $clog2(ITER_CYCLES + 1) : 5;
    localparam int MUL_STEPS   = 7;
    localparam int NUM_W       = 32 + ANGLE_FRAC_BITS;
    localparam int QUO_W       = ANGLE_FRAC_BITS + 15;
    localparam int REM_W       = 20;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = ANGLE_FRAC_BITS + 16;
    localparam int XY_W        = 42;
    localparam int Z_W         = 34;
    localparam int EST_W       = ANGLE_FRAC_BITS + 14;
    localparam int ACC_W       = ANGLE_FRAC_BITS + 10;
    localparam int DIFF_W      = EST_W + 1;
    localparam int PROD_W      = EST_W + 18;
    localparam int SAT_W       = EST_W + 19;
    localparam int Z_SHIFT     = TABLE_FRAC - ANGLE_FRAC_BITS;
    localparam int Z_HALF      = (Z_SHIFT > 0) ? (1 << (Z_SHIFT - 1)) : 0;
    localparam int DEG_W       = 14;

    // Reciprocal of the gyro divisor, scaled so that the estimate undershoots by
    // less than two; the remainder then corrects it.
    localparam logic [RECIP_W-1:0] GYRO_RECIP =
        RECIP_W'((longint'(1) << (RECIP_SHIFT + ANGLE_FRAC_BITS)) / GYRO_DIV);

    localparam logic signed [EST_W-1:0] ANGLE_LIM =
        EST_W'(longint'(4096) << ANGLE_FRAC_BITS);
    localparam logic signed [Z_W-1:0] Z_HALF_TURN = Z_W'(longint'(180) << TABLE_FRAC);

    typedef enum logic [2:0] {
        MS_RATE_X,
        MS_RATE_Y,
        MS_ACC_X,
        MS_ACC_Y,
        MS_ACC_Z,
        MS_HI,
        MS_LO
    } t_mul_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_ITER,
        S_PRED,
        S_PROD,
        S_BLEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             in_load;
        logic             mul_en;
        t_mul_sel         mul_sel;
        logic             iter_load;
        logic             iter_en;
        logic [CNT_W-1:0] iter_idx;
        logic             pred_en;
        logic             prod_en;
        logic             blend_en;
        logic             out_load;
    } t_dp_cmd;

    // atan(2^-i) in degrees with 24 fraction bits.
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
        case (idx)
            5'd0:    return Z_W'(754974720);
            5'd1:    return Z_W'(445687602);
            5'd2:    return Z_W'(235489088);
            5'd3:    return Z_W'(119537938);
            5'd4:    return Z_W'(60000934);
            5'd5:    return Z_W'(30029717);
            5'd6:    return Z_W'(15018523);
            5'd7:    return Z_W'(7509720);
            5'd8:    return Z_W'(3754917);
            5'd9:    return Z_W'(1877466);
            5'd10:   return Z_W'(938734);
            5'd11:   return Z_W'(469367);
            5'd12:   return Z_W'(234684);
            5'd13:   return Z_W'(117342);
            5'd14:   return Z_W'(58671);
            5'd15:   return Z_W'(29335);
            5'd16:   return Z_W'(14668);
            5'd17:   return Z_W'(7334);
            5'd18:   return Z_W'(3667);
            5'd19:   return Z_W'(1833);
            5'd20:   return Z_W'(917);
            5'd21:   return Z_W'(458);
            5'd22:   return Z_W'(229);
            5'd23:   return Z_W'(115);
            default: return '0;
        endcase
    endfunction

    // Clamp a wide angle to +-4096 degrees.
    function automatic logic signed [EST_W-1:0] sat_angle(input logic signed [SAT_W-1:0] v);
        if (v > SAT_W'(ANGLE_LIM)) begin
            return ANGLE_LIM;
        end else if (v < -SAT_W'(ANGLE_LIM)) begin
            return -ANGLE_LIM;
        end
        return EST_W'(v);
    endfunction

endpackage
`default_nettype wire

### sv/imu_tilt_complementary_filter_core.sv
// IMU tilt complementary filter, top level. An item runs from the input transfer
// through the shared-multiplier steps, a load step, the CORDIC iterations (the gyro
// step divider finishes during them), prediction, product, blend and output.
// One item is in work at a time, and the next transfer is taken only in the idle
// state after the result is loaded into the output register. Synchronous
// active-low reset clears the estimates and loads gain 29491 and tolerance 2458.
`default_nettype none
module imu_tilt_complementary_filter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], rate_x[63:48],
    // rate_y[79:64], elapsed_ms[95:80]
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // roll_deg[13:0], pitch_deg[27:14], zero fill[31:28]
    output logic [31:0]      m_axis_tdata,
    // accel_trusted[0]
    output logic             m_axis_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam logic CFG_BLEND_GAIN = 1'b0;
    localparam logic CFG_ACCEL_TOL  = 1'b1;

    logic [15:0] r_blend_gain;
    logic [14:0] r_accel_tol;

    imutcf_pkg::t_dp_cmd cmd;
    logic signed [13:0]  roll_deg, pitch_deg;
    logic                accel_trusted;

    // Configuration registers. Writes are expected only while no item is in work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_gain <= 16'd29491;
            r_accel_tol  <= 15'd2458;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_BLEND_GAIN: r_blend_gain <= i_cfg_wdata;
                CFG_ACCEL_TOL:  r_accel_tol  <= i_cfg_wdata[14:0];
                default:        r_blend_gain <= r_blend_gain;
            endcase
        end
    end

    // The controller sequences every phase; the output register lets a finished
    // result wait while the next item is taken and processed up to its output load.
    imutcf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    imutcf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_accel_x         ($signed(s_axis_tdata[15:0])),
        .i_accel_y         ($signed(s_axis_tdata[31:16])),
        .i_accel_z         ($signed(s_axis_tdata[47:32])),
        .i_rate_x          ($signed(s_axis_tdata[63:48])),
        .i_rate_y          ($signed(s_axis_tdata[79:64])),
        .i_elapsed_ms      (s_axis_tdata[95:80]),
        .i_blend_gain      (r_blend_gain),
        .i_accel_tolerance (r_accel_tol),
        .o_roll_deg        (roll_deg),
        .o_pitch_deg       (pitch_deg),
        .o_accel_trusted   (accel_trusted)
    );

    assign m_axis_tdata = {4'b0000, pitch_deg, roll_deg};
    assign m_axis_tuser = accel_trusted;

endmodule
`default_nettype wire

### sv/imutcf_ctrl.sv
// Sequencing state machine of the IMU tilt filter: steps the datapath through multiply,
// load, iterate, predict, product, blend and output phases. Depends on imutcf_pkg.
`default_nettype none
module imutcf_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output imutcf_pkg::t_dp_cmd     o_cmd
);

    localparam int MSW = $bits(imutcf_pkg::t_mul_sel);

    imutcf_pkg::t_state r_state, n_state;
    logic [imutcf_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imutcf_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_sel  = imutcf_pkg::t_mul_sel'(r_cnt[MSW-1:0]);
        o_cmd.iter_idx = r_cnt;
        unique case (r_state)
            imutcf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_cnt   = '0;
                    n_state = imutcf_pkg::S_MUL;
                end
            end
            imutcf_pkg::S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_cnt == imutcf_pkg::CNT_W'(imutcf_pkg::MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = imutcf_pkg::S_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            imutcf_pkg::S_LOAD: begin
                o_cmd.iter_load = 1'b1;
                n_cnt   = '0;
                n_state = imutcf_pkg::S_ITER;
            end
            imutcf_pkg::S_ITER: begin
                o_cmd.iter_en = 1'b1;
                if (r_cnt == imutcf_pkg::CNT_W'(imutcf_pkg::ITER_CYCLES - 1)) begin
                    n_cnt   = '0;
                    n_state = imutcf_pkg::S_PRED;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            imutcf_pkg::S_PRED: begin
                o_cmd.pred_en = 1'b1;
                n_state = imutcf_pkg::S_PROD;
            end
            imutcf_pkg::S_PROD: begin
                o_cmd.prod_en = 1'b1;
                n_state = imutcf_pkg::S_BLEND;
            end
            imutcf_pkg::S_BLEND: begin
                o_cmd.blend_en = 1'b1;
                n_state = imutcf_pkg::S_DONE;
            end
            imutcf_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = imutcf_pkg::S_IDLE;
                end
            end
            default: n_state = imutcf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

### sv/imutcf_lane.sv
// One angle lane: iterative CORDIC atan2, reciprocal gyro step divider, blend
// and the saturated angle estimate. Depends on imutcf_pkg.
`default_nettype none
module imutcf_lane (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire imutcf_pkg::t_dp_cmd          i_cmd,
    input  wire logic signed [15:0]           i_y,
    input  wire logic signed [15:0]           i_x,
    input  wire logic signed [33:0]           i_rate_prod,
    input  wire logic                         i_trusted,
    input  wire logic signed [16:0]           i_gain,
    output logic signed [imutcf_pkg::DEG_W-1:0] o_deg
);

    localparam int F     = imutcf_pkg::ANGLE_FRAC_BITS;
    localparam int XY_W  = imutcf_pkg::XY_W;
    localparam int Z_W   = imutcf_pkg::Z_W;
    localparam int NUM_W = imutcf_pkg::NUM_W;
    localparam int QUO_W = imutcf_pkg::QUO_W;
    localparam int REM_W = imutcf_pkg::REM_W;
    localparam int RP_W  = 31 + imutcf_pkg::RECIP_W;
    localparam int CW    = imutcf_pkg::CNT_W;
    localparam int EST_W = imutcf_pkg::EST_W;
    localparam int ACC_W = imutcf_pkg::ACC_W;
    localparam int SAT_W = imutcf_pkg::SAT_W;

    logic signed [XY_W-1:0]   r_x, r_y;
    logic signed [Z_W-1:0]    r_z;
    logic                     r_zero;
    logic [QUO_W-1:0]         r_q0, r_quo;
    logic [REM_W-1:0]         r_rem;
    logic                     r_neg;
    logic signed [EST_W-1:0]  r_est, r_pred;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [imutcf_pkg::PROD_W-1:0] r_prod;

    logic signed [XY_W-1:0]   x0, y0, xs, ys;
    logic signed [Z_W-1:0]    atan_v;
    logic [33:0]              rate_mag;
    logic [30:0]              a_mag;
    logic [RP_W-1:0]          recip_p;
    logic [NUM_W-1:0]         num0, qmul, rem_full;
    logic [Z_W-1:0]           zmag, zrnd;
    logic signed [ACC_W-1:0]  acc_pos, acc_val;
    logic signed [EST_W+1:0]  dq, delta;
    logic signed [SAT_W-1:0]  psum, bsum, bval;
    logic [SAT_W-1:0]         bmag, bq;
    logic signed [imutcf_pkg::DIFF_W-1:0] diff;
    logic [EST_W-1:0]         emag, dmag;
    logic signed [imutcf_pkg::DEG_W-1:0] dpos;

    always_comb begin
        x0       = XY_W'(i_x) <<< imutcf_pkg::TABLE_FRAC;
        y0       = XY_W'(i_y) <<< imutcf_pkg::TABLE_FRAC;
        xs       = r_x >>> i_cmd.iter_idx;
        ys       = r_y >>> i_cmd.iter_idx;
        atan_v   = imutcf_pkg::atan_q24(i_cmd.iter_idx[4:0]);
        rate_mag = i_rate_prod[33] ? 34'(-i_rate_prod) : 34'(i_rate_prod);
        a_mag    = rate_mag[30:0];
        recip_p  = RP_W'(a_mag) * RP_W'(imutcf_pkg::GYRO_RECIP);
        num0     = (NUM_W'(a_mag) << F) + NUM_W'(imutcf_pkg::GYRO_HALF);
        qmul     = NUM_W'(r_q0) * NUM_W'(imutcf_pkg::GYRO_DIV);
        rem_full = num0 - qmul;
        zmag     = r_z[Z_W-1] ? Z_W'(-r_z) : Z_W'(r_z);
        zrnd     = (zmag + Z_W'(imutcf_pkg::Z_HALF)) >> imutcf_pkg::Z_SHIFT;
        acc_pos  = $signed(zrnd[ACC_W-1:0]);
        acc_val  = r_zero ? '0 : (r_z[Z_W-1] ? -acc_pos : acc_pos);
        dq       = $signed({1'b0, r_quo});
        delta    = r_neg ? -dq : dq;
        psum     = SAT_W'(r_est) + SAT_W'(delta);
        diff     = imutcf_pkg::DIFF_W'(r_pred) - imutcf_pkg::DIFF_W'(r_acc);
        bsum     = SAT_W'(r_prod) + (SAT_W'(r_acc) <<< imutcf_pkg::GAIN_SHIFT);
        bmag     = bsum[SAT_W-1] ? SAT_W'(-bsum) : SAT_W'(bsum);
        bq       = (bmag + SAT_W'(imutcf_pkg::GAIN_ONE / 2)) >> imutcf_pkg::GAIN_SHIFT;
        bval     = bsum[SAT_W-1] ? -$signed(bq) : $signed(bq);
        emag     = r_est[EST_W-1] ? EST_W'(-r_est) : EST_W'(r_est);
        dmag     = (emag + EST_W'(longint'(1) << (F - 1))) >> F;
        dpos     = $signed(dmag[imutcf_pkg::DEG_W-1:0]);
        o_deg    = r_est[EST_W-1] ? -dpos : dpos;
    end

    // CORDIC rotation runs every iteration cycle. The gyro step quotient is formed at
    // iteration indexes 0, 1 and 2: reciprocal estimate, remainder, then the remainder correction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.iter_load) begin
            r_zero <= (i_x == 16'sd0) && (i_y == 16'sd0);
            if (i_x < 0) begin
                r_x <= -x0;
                r_y <= -y0;
                r_z <= (i_y >= 0) ? imutcf_pkg::Z_HALF_TURN : -imutcf_pkg::Z_HALF_TURN;
            end else begin
                r_x <= x0;
                r_y <= y0;
                r_z <= '0;
            end
            r_neg <= i_rate_prod[33];
        end else if (i_cmd.iter_en) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_v;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_v;
            end
            if (i_cmd.iter_idx == CW'(0)) begin
                r_q0 <= recip_p[RP_W-1:imutcf_pkg::RECIP_SHIFT];
            end
            if (i_cmd.iter_idx == CW'(1)) begin
                r_rem <= rem_full[REM_W-1:0];
            end
            if (i_cmd.iter_idx == CW'(2)) begin
                r_quo <= r_q0 + QUO_W'(r_rem >= REM_W'(imutcf_pkg::GYRO_DIV))
                              + QUO_W'(r_rem >= REM_W'(2 * imutcf_pkg::GYRO_DIV));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pred_en) begin
            r_pred <= imutcf_pkg::sat_angle(psum);
            r_acc  <= acc_val;
        end
        if (i_cmd.prod_en) begin
            r_prod <= i_gain * diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
        end else if (i_cmd.blend_en) begin
            r_est <= i_trusted ? imutcf_pkg::sat_angle(bval) : r_pred;
        end
    end

endmodule
`default_nettype wire

### sv/imutcf_dp.sv
// Datapath of the IMU tilt filter: input capture, shared multiplier, magnitude
// check, roll and pitch lanes and output registers. Depends on imutcf_pkg, imutcf_lane.
`default_nettype none
module imutcf_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire imutcf_pkg::t_dp_cmd i_cmd,
    input  wire logic signed [15:0]  i_accel_x,
    input  wire logic signed [15:0]  i_accel_y,
    input  wire logic signed [15:0]  i_accel_z,
    input  wire logic signed [15:0]  i_rate_x,
    input  wire logic signed [15:0]  i_rate_y,
    input  wire logic [15:0]         i_elapsed_ms,
    input  wire logic [15:0]         i_blend_gain,
    input  wire logic [14:0]         i_accel_tolerance,
    output logic signed [13:0]       o_roll_deg,
    output logic signed [13:0]       o_pitch_deg,
    output logic                     o_accel_trusted
);

    logic signed [15:0] r_ax, r_ay, r_az, r_rx, r_ry;
    logic [15:0]        r_ms;
    logic signed [33:0] r_prod_x, r_prod_y;
    logic [32:0]        r_m2, r_hi2, r_lo2;
    logic               r_trusted;
    logic signed [13:0] r_roll, r_pitch;
    logic               r_trusted_out;

    logic signed [16:0] mul_a, mul_b, hi, lo, gain;
    logic signed [33:0] mul_p;
    logic               trusted;
    logic signed [13:0] roll_deg, pitch_deg;

    assign hi = $signed(17'(imutcf_pkg::ONE_G) + {2'b00, i_accel_tolerance});
    assign lo = $signed(17'(imutcf_pkg::ONE_G) - {2'b00, i_accel_tolerance});

    always_comb begin
        case (i_cmd.mul_sel)
            imutcf_pkg::MS_RATE_X: begin
                mul_a = 17'(r_rx);
                mul_b = $signed({1'b0, r_ms});
            end
            imutcf_pkg::MS_RATE_Y: begin
                mul_a = 17'(r_ry);
                mul_b = $signed({1'b0, r_ms});
            end
            imutcf_pkg::MS_ACC_X: begin
                mul_a = 17'(r_ax);
                mul_b = 17'(r_ax);
            end
            imutcf_pkg::MS_ACC_Y: begin
                mul_a = 17'(r_ay);
                mul_b = 17'(r_ay);
            end
            imutcf_pkg::MS_ACC_Z: begin
                mul_a = 17'(r_az);
                mul_b = 17'(r_az);
            end
            imutcf_pkg::MS_HI: begin
                mul_a = hi;
                mul_b = hi;
            end
            imutcf_pkg::MS_LO: begin
                mul_a = lo;
                mul_b = lo;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Magnitude window test; the lower bound only applies when it is not negative.
    assign trusted = (r_m2 < r_hi2) && !(!lo[16] && (r_m2 <= r_lo2));
    assign gain = ({1'b0, i_blend_gain} > 17'(imutcf_pkg::GAIN_ONE))
                  ? 17'(imutcf_pkg::GAIN_ONE) : $signed({1'b0, i_blend_gain});

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_rx <= i_rate_x;
            r_ry <= i_rate_y;
            r_ms <= i_elapsed_ms;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                imutcf_pkg::MS_RATE_X: r_prod_x <= mul_p;
                imutcf_pkg::MS_RATE_Y: r_prod_y <= mul_p;
                imutcf_pkg::MS_ACC_X:  r_m2 <= mul_p[32:0];
                imutcf_pkg::MS_HI:     r_hi2 <= mul_p[32:0];
                imutcf_pkg::MS_LO:     r_lo2 <= mul_p[32:0];
                default:               r_m2 <= r_m2 + mul_p[32:0];
            endcase
        end
        if (i_cmd.pred_en) begin
            r_trusted <= trusted;
        end
        if (i_cmd.out_load) begin
            r_roll        <= roll_deg;
            r_pitch       <= pitch_deg;
            r_trusted_out <= r_trusted;
        end
    end

    imutcf_lane u_roll (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_y         (r_ay),
        .i_x         (r_az),
        .i_rate_prod (r_prod_x),
        .i_trusted   (r_trusted),
        .i_gain      (gain),
        .o_deg       (roll_deg)
    );

    imutcf_lane u_pitch (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_y         (r_ax),
        .i_x         (r_az),
        .i_rate_prod (r_prod_y),
        .i_trusted   (r_trusted),
        .i_gain      (gain),
        .o_deg       (pitch_deg)
    );

    assign o_roll_deg      = r_roll;
    assign o_pitch_deg     = r_pitch;
    assign o_accel_trusted = r_trusted_out;

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for imu_tilt_complementary_filter_core.
// Drives tilt samples over the input stream, predicts roll, pitch and the trust flag
// with a fixed-point filter model of its own, and checks every result transfer.
`default_nettype none
module tb_top;

    // Register indexes of the configuration port.
    localparam logic REG_BLEND_GAIN = 1'b0;
    localparam logic REG_ACCEL_TOL  = 1'b1;

    localparam int     CLK_HALF     = 6;
    localparam int     ITEM_LATENCY = 28;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     FRAC         = imutcf_pkg::ANGLE_FRAC_BITS;
    localparam int     TFRAC        = imutcf_pkg::TABLE_FRAC;
    localparam longint FRAC_ONE     = longint'(1) << FRAC;
    localparam longint ANGLE_MAX    = longint'(4096) << FRAC;
    localparam longint GAIN_FULL    = longint'(imutcf_pkg::GAIN_ONE);

    // atan(2^-i) in degrees with 24 fraction bits.
    localparam longint ATAN_DEG_Q24 [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // One input sample; the last field sits in the lowest bits of tdata.
    typedef struct packed {
        logic [15:0]        elapsed_ms;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } t_imu_sample;

    typedef struct packed {
        logic [13:0] roll;
        logic [13:0] pitch;
        logic        trusted;
    } t_tilt_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = REG_BLEND_GAIN;
    logic [15:0] i_cfg_wdata = '0;

    imu_tilt_complementary_filter_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Samples waiting to be offered, and results the filter model says must come back.
    t_imu_sample  sample_queue[$];
    t_tilt_result tilt_expected[$];

    // Filter model state and its copy of the registers.
    longint roll_est  = 0;
    longint pitch_est = 0;
    longint gain_reg  = 29491;
    longint tol_reg   = 2458;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;
    bit hold_done     = 1'b0;
    int hold_count    = 0;
    int mismatch_count = 0;
    int cycle_count   = 0;

    // Division rounded half away from zero, for a positive divisor.
    function automatic longint div_round(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clamp_angle(longint v);
        if (v > ANGLE_MAX) return ANGLE_MAX;
        if (v < -ANGLE_MAX) return -ANGLE_MAX;
        return v;
    endfunction

    // Vectoring CORDIC atan2 in degrees. A negative x first swings the vector
    // by half a turn, choosing +180 when y is zero or positive.
    function automatic longint tilt_atan2(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x <<< TFRAC;
        y = y <<< TFRAC;
        if (x < 0) begin
            z = (y >= 0) ? (longint'(180) <<< TFRAC) : -(longint'(180) <<< TFRAC);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < imutcf_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += ATAN_DEG_Q24[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ATAN_DEG_Q24[i];
            end
        end
        return div_round(z, longint'(1) << (TFRAC - FRAC));
    endfunction

    // Gyro integration, then the blend toward the accelerometer angle if trusted.
    function automatic longint blend_angle(longint est, longint rate, longint ms,
                                           longint acc_angle, bit trusted, longint gain);
        longint pred;
        pred = clamp_angle(est + div_round(rate * ms * FRAC_ONE,
                                           longint'(imutcf_pkg::GYRO_DIV)));
        if (!trusted) return pred;
        return clamp_angle(div_round(gain * pred + (GAIN_FULL - gain) * acc_angle,
                                     GAIN_FULL));
    endfunction

    function automatic logic [13:0] to_degrees(longint v);
        longint d;
        d = div_round(v, FRAC_ONE);
        return d[13:0];
    endfunction

    // Advance the filter model by one sample and queue the result it predicts.
    task automatic predict_tilt(input t_imu_sample s);
        longint ax, ay, az, mag2, lo, hi, gain;
        bit     trusted;
        t_tilt_result r;
        ax = longint'(s.accel_x);
        ay = longint'(s.accel_y);
        az = longint'(s.accel_z);
        mag2 = ax * ax + ay * ay + az * az;
        lo = longint'(imutcf_pkg::ONE_G) - tol_reg;
        hi = longint'(imutcf_pkg::ONE_G) + tol_reg;
        trusted = mag2 < hi * hi;
        if (lo >= 0 && mag2 <= lo * lo) trusted = 1'b0;
        gain = (gain_reg > GAIN_FULL) ? GAIN_FULL : gain_reg;
        roll_est = blend_angle(roll_est, longint'(s.rate_x), longint'(s.elapsed_ms),
                               tilt_atan2(ay, az), trusted, gain);
        pitch_est = blend_angle(pitch_est, longint'(s.rate_y), longint'(s.elapsed_ms),
                                tilt_atan2(ax, az), trusted, gain);
        r.roll = to_degrees(roll_est);
        r.pitch = to_degrees(pitch_est);
        r.trusted = trusted;
        tilt_expected.push_back(r);
    endtask

    // Driver: an accepted transfer is predicted at the edge that takes it, and the
    // next sample (or an idle cycle) is chosen with a single assignment per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_tilt(t_imu_sample'(s_axis_tdata));
            end
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata <= sample_queue.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, plus one long hold-off that makes the core
    // back up and drop its input ready while the driver keeps offering samples.
    always @(posedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_done <= 1'b1;
            hold_count <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_tilt_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tilt_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result roll=%0d pitch=%0d trusted=%0b",
                             $signed(m_axis_tdata[13:0]), $signed(m_axis_tdata[27:14]),
                             m_axis_tuser);
            end else begin
                want = tilt_expected.pop_front();
                if (m_axis_tdata[13:0] !== want.roll || m_axis_tdata[27:14] !== want.pitch
                    || m_axis_tuser !== want.trusted || m_axis_tdata[31:28] !== 4'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"ERROR: expected roll=%0d pitch=%0d trusted=%0b, ",
                                  "got %0d %0d %0b (fill %h)"},
                                 $signed(want.roll), $signed(want.pitch), want.trusted,
                                 $signed(m_axis_tdata[13:0]), $signed(m_axis_tdata[27:14]),
                                 m_axis_tuser, m_axis_tdata[31:28]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Wait until the core has nothing left in flight.
    task automatic drain();
        while (sample_queue.size() > 0 || tilt_expected.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (ITEM_LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        if (idx == REG_BLEND_GAIN) gain_reg = longint'(value);
        else tol_reg = longint'(value[14:0]);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample(input int ax, input int ay, input int az,
                              input int rx, input int ry, input int ms);
        t_imu_sample s;
        s.accel_x = 16'(ax);
        s.accel_y = 16'(ay);
        s.accel_z = 16'(az);
        s.rate_x = 16'(rx);
        s.rate_y = 16'(ry);
        s.elapsed_ms = 16'(ms);
        sample_queue.push_back(s);
    endtask

    // Mostly plausible motion: an acceleration vector near one g in a random
    // direction and modest gyro steps. One in five samples is raw noise.
    task automatic add_random(input int count);
        real g, ax, ay, rest;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(4) == 0) begin
                sample_queue.push_back(t_imu_sample'({$urandom, $urandom, $urandom}));
            end else begin
                g = 16384.0 * (0.8 + 0.4 * $urandom_range(1000) / 1000.0);
                ax = (($urandom_range(2000) / 1000.0) - 1.0) * g * 0.7;
                ay = (($urandom_range(2000) / 1000.0) - 1.0) * g * 0.7;
                rest = g * g - ax * ax - ay * ay;
                rest = (rest > 0.0) ? $sqrt(rest) : 0.0;
                if ($urandom_range(3) == 0) rest = -rest;
                add_sample(int'(ax), int'(ay), int'(rest),
                           $signed($urandom_range(6000)) - 3000,
                           $signed($urandom_range(6000)) - 3000,
                           int'($urandom_range(($urandom_range(9) == 0) ? 65535 : 40)));
            end
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode % 3)
            0: begin send_idle_pct = 18; recv_idle_pct = 64; end
            1: begin send_idle_pct = 64; recv_idle_pct = 18; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);

        // Directed samples at the default registers.
        add_sample(0, 0, 16384, 0, 0, 10);             // level and still
        add_sample(0, 0, 0, 0, 0, 0);                  // zero vector: angle 0, untrusted
        add_sample(0, 0, -16384, 0, 0, 5);             // upside down: start at +180
        add_sample(-16384, 0, -1, 0, 0, 5);            // negative z, zero y
        add_sample(0, -16384, -1, 0, 0, 5);            // negative z, zero x
        add_sample(16384, 16384, 0, 0, 0, 5);          // z zero
        add_sample(-32768, -32768, -32768, -32768, -32768, 65535);
        add_sample(32767, 32767, 32767, 32767, 32767, 65535);
        add_sample(0, 0, 16384 + 2457, 32767, -32768, 65535); // just inside the upper bound
        add_sample(0, 0, 16384 + 2458, -32768, 32767, 65535); // on the upper bound
        add_sample(0, 0, 16384 - 2458, 131, -131, 1000);      // on the lower bound
        add_sample(0, 0, 16384 - 2457, 131, -131, 1000);      // just inside the lower bound
        add_sample(11585, 0, 11585, 0, 0, 20);
        add_sample(0, -11585, 11585, 0, 0, 20);
        add_random(180);
        drain();

        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_BLEND_GAIN, 16'd0);
                    write_reg(REG_ACCEL_TOL, 16'd0);
                end
                2: begin
                    write_reg(REG_BLEND_GAIN, 16'd32768);
                    write_reg(REG_ACCEL_TOL, 16'd16384);
                end
                3: begin
                    write_reg(REG_BLEND_GAIN, 16'hFFFF);
                    write_reg(REG_ACCEL_TOL, 16'h7FFF);
                end
                4: begin
                    write_reg(REG_BLEND_GAIN, 16'd16384);
                    write_reg(REG_ACCEL_TOL, 16'd20000);
                end
                5: begin
                    write_reg(REG_BLEND_GAIN, 16'd32767);
                    write_reg(REG_ACCEL_TOL, 16'd1);
                end
                default: begin
                    write_reg(REG_BLEND_GAIN, 16'($urandom_range(32768)));
                    write_reg(REG_ACCEL_TOL, 16'($urandom_range(4000)));
                end
            endcase
            set_idling(phase);
            // Exactly one g tolerance keeps a zero vector out; others probe the bounds.
            add_sample(0, 0, 0, 100, -100, 30);
            add_sample(0, 0, 16384, 0, 0, 1);
            add_sample(0, 0, 32767, -5000, 5000, 100);
            if (phase == 2) hold_request = 1'b1;
            add_random(150);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### imu_tilt_complementary_filter_core.f
sv/imutcf_pkg.sv
sv/imutcf_ctrl.sv
sv/imutcf_lane.sv
sv/imutcf_dp.sv
sv/imu_tilt_complementary_filter_core.sv
tb/tb_top.sv
